### design/asgr_pkg.sv
// types, constants and helpers shared by the sgr escape parser modules
`default_nettype none

package asgr_pkg;

	localparam logic [7:0] BYTE_ESC      = 8'h1B;
	localparam logic [7:0] BYTE_LF       = 8'h0A;
	localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [7:0] BYTE_LPAREN   = 8'h28;
	localparam logic [7:0] BYTE_SEMI     = 8'h3B;
	localparam logic [7:0] BYTE_M        = 8'h6D;
	localparam logic [7:0] BYTE_ZERO     = 8'h30;
	localparam logic [7:0] BYTE_NINE     = 8'h39;
	localparam logic [7:0] PRINT_LO      = 8'h20;
	localparam logic [7:0] PRINT_HI      = 8'h7E;

	localparam logic [7:0] SGR_RESET     = 8'd0;
	localparam logic [7:0] SGR_UNDERLINE = 8'd4;
	localparam logic [7:0] SGR_SWAP      = 8'd7;
	localparam logic [7:0] SGR_FG_BASE   = 8'd30;
	localparam logic [7:0] SGR_FG_LAST   = 8'd39;
	localparam logic [7:0] SGR_BG_BASE   = 8'd40;
	localparam logic [7:0] SGR_BG_LAST   = 8'd49;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_NEWLINE = 1'b1;

	localparam logic REG_DEFAULT_FG = 1'b0;
	localparam logic REG_DEFAULT_BG = 1'b1;

	localparam logic [3:0] RESET_FG = 4'd15;
	localparam logic [3:0] RESET_BG = 4'd0;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_CHAR      = 3'd0,
		OP_NEWLINE   = 3'd1,
		OP_RESET     = 3'd2,
		OP_UNDERLINE = 3'd3,
		OP_SWAP      = 3'd4,
		OP_FG        = 3'd5,
		OP_BG        = 3'd6
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] arg;
	} cmd_t;

	function automatic logic [3:0] palette(input logic [3:0] digit);
		palette = (digit >= 4'd1 && digit <= 4'd7) ? digit : 4'd0;
	endfunction

endpackage

`default_nettype wire

### design/ansi_sgr_escape_parser.sv
// a byte's command is held in the command queue, then any result word in the result queue
// throughput: one byte per cycle, sustained while pop keeps up with the result queue
// a two-word command queue parts the parser from the executor, a two-word queue holds results
// reset (arst_n low) clears parser, attributes to default colors, cursor and both queues
// top level: ansi sgr escape parser with queue-style input and result ports
`default_nettype none

module ansi_sgr_escape_parser #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS    = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [7:0]             in_byte,
	output logic                        full,
	input  wire logic                   cfg_write,
	input  wire logic                   cfg_index,
	input  wire logic [3:0]             cfg_data,
	output logic                        empty,
	input  wire logic                   pop,
	output logic                        kind,
	output logic [6:0]                  char_code,
	output logic [3:0]                  fg_color,
	output logic [3:0]                  bg_color,
	output logic                        underline,
	output logic [COLUMN_BITS-1:0]      column,
	output logic [ROW_BITS-1:0]         row
);
	import asgr_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = 17 + COLUMN_BITS + ROW_BITS;

	logic             accept;
	logic             cmd_push;
	cmd_t             front_cmd;
	logic [CMD_W-1:0] cmd_word;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	logic [RES_W-1:0] res_word;
	logic [RES_W-1:0] out_word;

	assign accept = push & ~full;

	asgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	asgr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (front_cmd),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (cmd_word),
		.empty   (cmd_empty)
	);

	asgr_back #(
		.COLUMN_BITS (COLUMN_BITS),
		.ROW_BITS    (ROW_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_t'(cmd_word)),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_word  (res_word)
	);

	asgr_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_word),
		.full    (res_full),
		.pop     (pop),
		.rd_data (out_word),
		.empty   (empty)
	);

	assign {kind, char_code, fg_color, bg_color, underline, column, row} = out_word;

endmodule

`default_nettype wire

### design/asgr_fifo.sv
// small flop-based queue used between the parser stages and at the result side
`default_nettype none

module asgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/asgr_front.sv
// front stage: escape sequence parser that turns bytes into commands
`default_nettype none

module asgr_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   in_byte,
	output logic              cmd_push,
	output asgr_pkg::cmd_t    cmd
);
	import asgr_pkg::*;

	typedef enum logic [3:0] {
		ST_TEXT = 4'b0001,
		ST_ESC  = 4'b0010,
		ST_FMT  = 4'b0100,
		ST_FONT = 4'b1000
	} pstate_t;

	pstate_t     state_q;
	pstate_t     state_d;
	logic [7:0]  accum_q;
	logic [7:0]  accum_d;
	logic [11:0] accum_sum;
	logic        is_digit;
	logic        code_valid;
	cmd_t        code_cmd;
	logic [7:0]  fg_off;
	logic [7:0]  bg_off;

	assign is_digit  = (in_byte >= BYTE_ZERO) && (in_byte <= BYTE_NINE);
	assign accum_sum = {4'b0, accum_q} * 12'd10 + {8'b0, in_byte[3:0]};
	assign fg_off    = accum_q - SGR_FG_BASE;
	assign bg_off    = accum_q - SGR_BG_BASE;

	// map the collected sgr code onto a back-end command
	always_comb begin
		code_valid   = 1'b1;
		code_cmd.op  = OP_RESET;
		code_cmd.arg = '0;
		priority if (accum_q == SGR_RESET) begin
			code_cmd.op = OP_RESET;
		end else if (accum_q == SGR_UNDERLINE) begin
			code_cmd.op = OP_UNDERLINE;
		end else if (accum_q == SGR_SWAP) begin
			code_cmd.op = OP_SWAP;
		end else if (accum_q >= SGR_FG_BASE && accum_q <= SGR_FG_LAST) begin
			code_cmd.op  = OP_FG;
			code_cmd.arg = {3'b0, palette(fg_off[3:0])};
		end else if (accum_q >= SGR_BG_BASE && accum_q <= SGR_BG_LAST) begin
			code_cmd.op  = OP_BG;
			code_cmd.arg = {3'b0, palette(bg_off[3:0])};
		end else begin
			code_valid = 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		accum_d  = accum_q;
		cmd_push = 1'b0;
		cmd.op   = OP_CHAR;
		cmd.arg  = in_byte[6:0];
		unique case (state_q)
			ST_TEXT: begin
				if (in_byte == BYTE_ESC) begin
					state_d = ST_ESC;
				end else if (in_byte == BYTE_LF) begin
					cmd_push = accept;
					cmd.op   = OP_NEWLINE;
					cmd.arg  = '0;
				end else if (in_byte >= PRINT_LO && in_byte <= PRINT_HI) begin
					cmd_push = accept;
				end
			end
			ST_ESC: begin
				accum_d = '0;
				if (in_byte == BYTE_LBRACKET) begin
					state_d = ST_FMT;
				end else if (in_byte == BYTE_LPAREN) begin
					state_d = ST_FONT;
				end
			end
			ST_FMT: begin
				if (is_digit) begin
					accum_d = (accum_sum > 12'd255) ? 8'hFF : accum_sum[7:0];
				end else if (in_byte == BYTE_SEMI || in_byte == BYTE_M) begin
					cmd_push = accept & code_valid;
					cmd      = code_cmd;
					if (in_byte == BYTE_SEMI) begin
						accum_d = '0;
					end else begin
						state_d = ST_TEXT;
					end
				end else begin
					state_d = ST_TEXT;
				end
			end
			ST_FONT: begin
				cmd_push = accept;
				cmd.op   = OP_RESET;
				cmd.arg  = '0;
				state_d  = ST_TEXT;
			end
			default: begin
				state_d = ST_TEXT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TEXT;
			accum_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
			accum_q <= accum_d;
		end
	end

endmodule

`default_nettype wire

### design/asgr_back.sv
// back stage: attribute and cursor state, executes commands and builds result words
`default_nettype none

module asgr_back #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS    = 16,
	localparam int RES_W      = 17 + COLUMN_BITS + ROW_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_index,
	input  wire logic [3:0]       cfg_data,
	input  wire asgr_pkg::cmd_t   cmd,
	input  wire logic             cmd_empty,
	output logic                  cmd_pop,
	input  wire logic             res_full,
	output logic                  res_push,
	output logic [RES_W-1:0]      res_word
);
	import asgr_pkg::*;

	logic [3:0]             default_fg_q;
	logic [3:0]             default_bg_q;
	logic [3:0]             fg_q;
	logic [3:0]             bg_q;
	logic                   ul_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [ROW_BITS-1:0]    row_next;
	logic                   needs_res;

	assign needs_res = (cmd.op == OP_CHAR) || (cmd.op == OP_NEWLINE);
	assign cmd_pop   = ~cmd_empty & (~needs_res | ~res_full);
	assign res_push  = cmd_pop & needs_res;
	assign row_next  = row_q + 1'b1;

	always_comb begin
		if (cmd.op == OP_NEWLINE) begin
			res_word = {KIND_NEWLINE, 7'd0, fg_q, bg_q, ul_q, {COLUMN_BITS{1'b0}}, row_next};
		end else begin
			res_word = {KIND_CHAR, cmd.arg, fg_q, bg_q, ul_q, col_q, row_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= RESET_FG;
			default_bg_q <= RESET_BG;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEFAULT_FG: default_fg_q <= cfg_data;
				REG_DEFAULT_BG: default_bg_q <= cfg_data;
				default:        default_fg_q <= default_fg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q  <= RESET_FG;
			bg_q  <= RESET_BG;
			ul_q  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd_pop) begin
			unique case (cmd.op)
				OP_CHAR: begin
					if (col_q != '1) begin
						col_q <= col_q + 1'b1;
					end
				end
				OP_NEWLINE: begin
					col_q <= '0;
					row_q <= row_next;
				end
				OP_RESET: begin
					fg_q <= default_fg_q;
					bg_q <= default_bg_q;
					ul_q <= 1'b0;
				end
				OP_UNDERLINE: ul_q <= 1'b1;
				OP_SWAP: begin
					fg_q <= bg_q;
					bg_q <= fg_q;
				end
				OP_FG:   fg_q <= cmd.arg[3:0];
				OP_BG:   bg_q <= cmd.arg[3:0];
				default: ul_q <= ul_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/asgr_checker.sv
// port-level checker for the sgr escape parser, bound to the top level
`default_nettype none

module asgr_checker #(
	parameter int COLUMN_BITS = 8,
	parameter int ROW_BITS    = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   empty,
	input wire logic                   pop,
	input wire logic                   kind,
	input wire logic [6:0]             char_code,
	input wire logic [3:0]             fg_color,
	input wire logic [3:0]             bg_color,
	input wire logic                   underline,
	input wire logic [COLUMN_BITS-1:0] column,
	input wire logic [ROW_BITS-1:0]    row
);
	import asgr_pkg::*;

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_newline_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_NEWLINE) |-> (char_code == 7'd0 && column == '0))
		else $error("newline word carries character or column");

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_CHAR) |-> (char_code >= PRINT_LO[6:0] && char_code != 7'h7F))
		else $error("character word carries a non-printable code");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(char_code)
			&& $stable(fg_color) && $stable(bg_color) && $stable(underline)
			&& $stable(column) && $stable(row)))
		else $error("waiting result changed before pop");

endmodule

bind ansi_sgr_escape_parser asgr_checker #(
	.COLUMN_BITS (COLUMN_BITS),
	.ROW_BITS    (ROW_BITS)
) u_asgr_checker (.*);

`default_nettype wire
